// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- src/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg
// shared types and constants of the segment intersection point unit
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int OUT_W = 32;
    localparam int QW    = OUT_W + 1;

    // orientation sign codes: {negative, nonzero}
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } sip_ctl_t;

endpackage

// ----- src/sip_front.sv -----
// ----------------------------------------------------------------------------
// sip_front
// orientation tests, denominator and determinant numerators in four stages
// ----------------------------------------------------------------------------
module sip_front
    import sip_pkg::*;
#(
    parameter int CW = 16,
    parameter int FW = 16,
    parameter int DW = 2 * CW + 3,
    parameter int NW = 3 * CW + 3 + FW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x1,
    input  logic signed [CW-1:0] y1,
    input  logic signed [CW-1:0] x2,
    input  logic signed [CW-1:0] y2,
    input  logic signed [CW-1:0] x3,
    input  logic signed [CW-1:0] y3,
    input  logic signed [CW-1:0] x4,
    input  logic signed [CW-1:0] y4,
    output sip_ctl_t             ctl,
    output logic        [DW-1:0] dmag,
    output logic        [NW-1:0] numx,
    output logic        [NW-1:0] numy
);

    localparam int EW  = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int CPW = 2 * CW;
    localparam int PQW = 2 * CW + 1;
    localparam int MPW = 3 * CW + 2;
    localparam int MW  = 3 * CW + 3;

    logic signed [EW-1:0] bax, bay, cbx, cby, dbx, dby, dcx, dcy;
    logic signed [EW-1:0] adx, ady, bdx, bdy, dx12, dy12, dx34, dy34;

    assign bax  = EW'(x2) - EW'(x1);
    assign bay  = EW'(y2) - EW'(y1);
    assign cbx  = EW'(x3) - EW'(x2);
    assign cby  = EW'(y3) - EW'(y2);
    assign dbx  = EW'(x4) - EW'(x2);
    assign dby  = EW'(y4) - EW'(y2);
    assign dcx  = EW'(x4) - EW'(x3);
    assign dcy  = EW'(y4) - EW'(y3);
    assign adx  = EW'(x1) - EW'(x4);
    assign ady  = EW'(y1) - EW'(y4);
    assign bdx  = EW'(x2) - EW'(x4);
    assign bdy  = EW'(y2) - EW'(y4);
    assign dx12 = EW'(x1) - EW'(x2);
    assign dy12 = EW'(y1) - EW'(y2);
    assign dx34 = EW'(x3) - EW'(x4);
    assign dy34 = EW'(y3) - EW'(y4);

    // stage a: products
    logic                  va_reg;
    logic signed [PW-1:0]  o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    logic signed [PW-1:0]  o3a_reg, o3b_reg, o4a_reg, o4b_reg, da_reg, db_reg;
    logic signed [CPW-1:0] pa_reg, pb_reg, qa_reg, qb_reg;
    logic signed [EW-1:0]  dx12a_reg, dy12a_reg, dx34a_reg, dy34a_reg;

    // stage b: sums
    logic                  vb_reg, hb_reg;
    logic signed [DW-1:0]  denb_reg;
    logic signed [PQW-1:0] p_reg, q_reg;
    logic signed [EW-1:0]  dx12b_reg, dy12b_reg, dx34b_reg, dy34b_reg;

    // stage c: numerator products
    logic                  vc_reg, hc_reg;
    logic signed [DW-1:0]  denc_reg;
    logic signed [MPW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;

    // stage d: magnitudes
    sip_ctl_t              ctl_reg;
    logic        [DW-1:0]  dmag_reg;
    logic        [MW-1:0]  magx_reg, magy_reg;

    logic signed [DW-1:0]  o1, o2, o3, o4, den_b;
    logic        [1:0]     s1, s2, s3, s4;
    logic signed [MW-1:0]  nx, ny;

    assign o1    = DW'(o1a_reg) - DW'(o1b_reg);
    assign o2    = DW'(o2a_reg) - DW'(o2b_reg);
    assign o3    = DW'(o3a_reg) - DW'(o3b_reg);
    assign o4    = DW'(o4a_reg) - DW'(o4b_reg);
    assign den_b = DW'(da_reg) - DW'(db_reg);

    assign s1 = (o1 == '0) ? SIGN_ZERO : (o1[DW-1] ? SIGN_NEG : SIGN_POS);
    assign s2 = (o2 == '0) ? SIGN_ZERO : (o2[DW-1] ? SIGN_NEG : SIGN_POS);
    assign s3 = (o3 == '0) ? SIGN_ZERO : (o3[DW-1] ? SIGN_NEG : SIGN_POS);
    assign s4 = (o4 == '0) ? SIGN_ZERO : (o4[DW-1] ? SIGN_NEG : SIGN_POS);

    assign nx = MW'(m1_reg) - MW'(m2_reg);
    assign ny = MW'(m3_reg) - MW'(m4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            ctl_reg.valid <= vc_reg;
            ctl_reg.hit   <= hc_reg;
            ctl_reg.neg_x <= nx[MW-1] ^ denc_reg[DW-1];
            ctl_reg.neg_y <= ny[MW-1] ^ denc_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o1a_reg   <= PW'(bay) * PW'(cbx);
            o1b_reg   <= PW'(bax) * PW'(cby);
            o2a_reg   <= PW'(bay) * PW'(dbx);
            o2b_reg   <= PW'(bax) * PW'(dby);
            o3a_reg   <= PW'(dcy) * PW'(adx);
            o3b_reg   <= PW'(dcx) * PW'(ady);
            o4a_reg   <= PW'(dcy) * PW'(bdx);
            o4b_reg   <= PW'(dcx) * PW'(bdy);
            da_reg    <= PW'(dx12) * PW'(dy34);
            db_reg    <= PW'(dy12) * PW'(dx34);
            pa_reg    <= CPW'(x1) * CPW'(y2);
            pb_reg    <= CPW'(y1) * CPW'(x2);
            qa_reg    <= CPW'(x3) * CPW'(y4);
            qb_reg    <= CPW'(y3) * CPW'(x4);
            dx12a_reg <= dx12;
            dy12a_reg <= dy12;
            dx34a_reg <= dx34;
            dy34a_reg <= dy34;

            hb_reg    <= (s1 != s2) && (s3 != s4);
            denb_reg  <= den_b;
            p_reg     <= PQW'(pa_reg) - PQW'(pb_reg);
            q_reg     <= PQW'(qa_reg) - PQW'(qb_reg);
            dx12b_reg <= dx12a_reg;
            dy12b_reg <= dy12a_reg;
            dx34b_reg <= dx34a_reg;
            dy34b_reg <= dy34a_reg;

            hc_reg    <= hb_reg && (denb_reg != '0);
            denc_reg  <= denb_reg;
            m1_reg    <= MPW'(p_reg) * MPW'(dx34b_reg);
            m2_reg    <= MPW'(dx12b_reg) * MPW'(q_reg);
            m3_reg    <= MPW'(p_reg) * MPW'(dy34b_reg);
            m4_reg    <= MPW'(dy12b_reg) * MPW'(q_reg);

            dmag_reg  <= denc_reg[DW-1] ? DW'(-denc_reg) : DW'(denc_reg);
            magx_reg  <= nx[MW-1] ? MW'(-nx) : MW'(nx);
            magy_reg  <= ny[MW-1] ? MW'(-ny) : MW'(ny);
        end
    end

    assign ctl  = ctl_reg;
    assign dmag = dmag_reg;
    assign numx = NW'(magx_reg) << FW;
    assign numy = NW'(magy_reg) << FW;

endmodule

// ----- src/sip_cell.sv -----
// ----------------------------------------------------------------------------
// sip_cell
// one restoring division step for both coordinates, registered
// ----------------------------------------------------------------------------
module sip_cell
    import sip_pkg::*;
#(
    parameter int DW = 35,
    parameter int NW = 67
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  sip_ctl_t      ctl_in,
    input  logic [DW-1:0] d_in,
    input  logic [DW-1:0] rx_in,
    input  logic [NW-1:0] nx_in,
    input  logic [QW-1:0] qx_in,
    input  logic          ox_in,
    input  logic [DW-1:0] ry_in,
    input  logic [NW-1:0] ny_in,
    input  logic [QW-1:0] qy_in,
    input  logic          oy_in,
    output sip_ctl_t      ctl_out,
    output logic [DW-1:0] d_out,
    output logic [DW-1:0] rx_out,
    output logic [NW-1:0] nx_out,
    output logic [QW-1:0] qx_out,
    output logic          ox_out,
    output logic [DW-1:0] ry_out,
    output logic [NW-1:0] ny_out,
    output logic [QW-1:0] qy_out,
    output logic          oy_out
);

    sip_ctl_t      ctl_reg;
    logic [DW-1:0] d_reg, rx_reg, ry_reg;
    logic [NW-1:0] nx_reg, ny_reg;
    logic [QW-1:0] qx_reg, qy_reg;
    logic          ox_reg, oy_reg;

    logic [DW:0]   shx, shy;
    logic          gex, gey;

    assign shx = {rx_in, nx_in[NW-1]};
    assign shy = {ry_in, ny_in[NW-1]};
    assign gex = shx >= {1'b0, d_in};
    assign gey = shy >= {1'b0, d_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg  <= d_in;
            rx_reg <= gex ? DW'(shx - {1'b0, d_in}) : shx[DW-1:0];
            ry_reg <= gey ? DW'(shy - {1'b0, d_in}) : shy[DW-1:0];
            nx_reg <= nx_in << 1;
            ny_reg <= ny_in << 1;
            // quotient bits shifted past the top mark an overflow
            qx_reg <= {qx_in[QW-2:0], gex};
            qy_reg <= {qy_in[QW-2:0], gey};
            ox_reg <= ox_in | qx_in[QW-1];
            oy_reg <= oy_in | qy_in[QW-1];
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;
    assign rx_out  = rx_reg;
    assign ry_out  = ry_reg;
    assign nx_out  = nx_reg;
    assign ny_out  = ny_reg;
    assign qx_out  = qx_reg;
    assign qy_out  = qy_reg;
    assign ox_out  = ox_reg;
    assign oy_out  = oy_reg;

endmodule

// ----- src/segment_intersection_point_unit.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// segment pair intersection test with fixed point crossing point
// ----------------------------------------------------------------------------
// one input transaction carries two segments (A-B and C-D) as eight signed
// coordinates; one output transaction returns hit and the crossing point in
// signed fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 32 bits; cross_x and cross_y are zero when hit is low.
// the pipeline runs through four front stages for orientation signs,
// denominator and numerators, one division cell per numerator bit, then
// the output register.
// throughput is one transaction per cycle while out_stall does not hold a
// waiting result, set by the chain of division cells, each of which retires
// one quotient bit of every transaction passing through it.
// when out_stall holds a waiting result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is lost or duplicated.
// reset clears all valid flags; no transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module segment_intersection_point_unit
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] first_start_x,
    input  logic signed [COORD_BITS-1:0] first_start_y,
    input  logic signed [COORD_BITS-1:0] first_end_x,
    input  logic signed [COORD_BITS-1:0] first_end_y,
    input  logic signed [COORD_BITS-1:0] second_start_x,
    input  logic signed [COORD_BITS-1:0] second_start_y,
    input  logic signed [COORD_BITS-1:0] second_end_x,
    input  logic signed [COORD_BITS-1:0] second_end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic signed [OUT_W-1:0]      cross_x,
    output logic signed [OUT_W-1:0]      cross_y
);

    localparam int DW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 3 + FRAC_BITS;

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    sip_ctl_t      ctl_c [NW+1];
    logic [DW-1:0] d_c   [NW+1];
    logic [DW-1:0] rx_c  [NW+1];
    logic [DW-1:0] ry_c  [NW+1];
    logic [NW-1:0] nx_c  [NW+1];
    logic [NW-1:0] ny_c  [NW+1];
    logic [QW-1:0] qx_c  [NW+1];
    logic [QW-1:0] qy_c  [NW+1];
    logic          ox_c  [NW+1];
    logic          oy_c  [NW+1];

    sip_front #(
        .CW (COORD_BITS),
        .FW (FRAC_BITS),
        .DW (DW),
        .NW (NW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .x1       (first_start_x),
        .y1       (first_start_y),
        .x2       (first_end_x),
        .y2       (first_end_y),
        .x3       (second_start_x),
        .y3       (second_start_y),
        .x4       (second_end_x),
        .y4       (second_end_y),
        .ctl      (ctl_c[0]),
        .dmag     (d_c[0]),
        .numx     (nx_c[0]),
        .numy     (ny_c[0])
    );

    assign rx_c[0] = '0;
    assign ry_c[0] = '0;
    assign qx_c[0] = '0;
    assign qy_c[0] = '0;
    assign ox_c[0] = 1'b0;
    assign oy_c[0] = 1'b0;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        sip_cell #(
            .DW (DW),
            .NW (NW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_c[i]),
            .d_in    (d_c[i]),
            .rx_in   (rx_c[i]),
            .nx_in   (nx_c[i]),
            .qx_in   (qx_c[i]),
            .ox_in   (ox_c[i]),
            .ry_in   (ry_c[i]),
            .ny_in   (ny_c[i]),
            .qy_in   (qy_c[i]),
            .oy_in   (oy_c[i]),
            .ctl_out (ctl_c[i+1]),
            .d_out   (d_c[i+1]),
            .rx_out  (rx_c[i+1]),
            .nx_out  (nx_c[i+1]),
            .qx_out  (qx_c[i+1]),
            .ox_out  (ox_c[i+1]),
            .ry_out  (ry_c[i+1]),
            .ny_out  (ny_c[i+1]),
            .qy_out  (qy_c[i+1]),
            .oy_out  (oy_c[i+1])
        );
    end

    sip_ctl_t          fin;
    logic [QW-1:0]     qx, qy;
    logic              satx, saty;
    logic [OUT_W-1:0]  vx, vy;
    logic              hit_reg;
    logic [OUT_W-1:0]  cx_reg, cy_reg;

    assign fin = ctl_c[NW];
    assign qx  = qx_c[NW];
    assign qy  = qy_c[NW];

    // negative results may reach one step further than positive ones
    assign satx = ox_c[NW] || qx[QW-1] ||
                  (qx[OUT_W-1] && (!fin.neg_x || (qx[OUT_W-2:0] != '0)));
    assign saty = oy_c[NW] || qy[QW-1] ||
                  (qy[OUT_W-1] && (!fin.neg_y || (qy[OUT_W-2:0] != '0)));

    always_comb
    begin
        if (satx)
            vx = fin.neg_x ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            vx = fin.neg_x ? OUT_W'(-qx[OUT_W-1:0]) : qx[OUT_W-1:0];
        if (saty)
            vy = fin.neg_y ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            vy = fin.neg_y ? OUT_W'(-qy[OUT_W-1:0]) : qy[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= fin.hit;
            cx_reg  <= fin.hit ? vx : '0;
            cy_reg  <= fin.hit ? vy : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;

endmodule

// ----- src/sip_checker.sv -----
// ----------------------------------------------------------------------------
// sip_checker
// port level checks of the segment intersection point unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sip_checker
    import sip_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    hit,
    input logic signed [OUT_W-1:0] cross_x,
    input logic signed [OUT_W-1:0] cross_y
);

    // no result leaves right after a reset cycle
    `ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)

    // input side only backs up when a result is held
    `ASSERT_CLK(a_stall_cause, clk, rst_n, in_stall == (out_valid && out_stall))

    // a miss never carries a point
    `ASSERT_CLK(a_miss_zero, clk, rst_n,
        (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))

    // a held result keeps its hit flag and cross_x
    `ASSERT_CLK(a_hold, clk, rst_n,
        (out_valid && out_stall) |=> (out_valid && $stable(cross_x) && $stable(hit)))

endmodule

bind segment_intersection_point_unit sip_checker u_sip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
);
